// ===== sv/assert_macros.svh =====
// Assertion macros shared by the stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a same-cycle implication on clk, quiet while arst_n is low.
`define PLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the next cycle on clk, quiet while arst_n is low.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pls_pkg.sv =====
// Package with sizes, status codes and controller command type for the stack block.
`timescale 1ns / 1ps
package pls_pkg;
	localparam int SLOTS      = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int SLOT_W     = $clog2(SLOTS + 1);
	localparam int POP_W      = 32;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 11;
	localparam int OUT_DATA_W = ((POP_W + SLOT_OUT_W + 7) / 8) * 8;

	// Operation codes carried in s_tuser
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Status codes carried in m_tuser
	localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;   // capture input word and start memory reads
		logic exec;   // update heads and memories, load output register
	} pls_cmd_t;
endpackage

// ===== sv/pls_ctrl.sv =====
// Controller state machine for the stack block: handshakes and sequencing.
`timescale 1ns / 1ps
module pls_ctrl
	import pls_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output logic     busy,
	output pls_cmd_t cmd
);
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// Accept only while idle; execute once the output register can take a word
	assign s_tready = (state_q == S_IDLE);
	assign busy     = (state_q == S_EXEC);
	assign m_tvalid = out_valid_q;
	assign cmd.load = s_tvalid && s_tready;
	assign cmd.exec = (state_q == S_EXEC) && (!out_valid_q || m_tready);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.exec) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== sv/pls_dp.sv =====
// Datapath for the stack block: heads, link and data memories, output register.
`timescale 1ns / 1ps
module pls_dp
	import pls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  pls_cmd_t              cmd,
	input  logic                  in_op,
	input  logic [31:0]           in_value,
	output logic [POP_W-1:0]      pop_value,
	output logic [STATUS_W-1:0]   status,
	output logic [SLOT_OUT_W-1:0] slot_used
);
	logic [SLOT_W-1:0]     link_mem [SLOTS+1];
	logic [DATA_WIDTH-1:0] data_mem [SLOTS+1];

	logic [SLOT_W-1:0]     top_q;
	logic [SLOT_W-1:0]     free_q;
	logic [SLOT_W-1:0]     fresh_q;      // lowest slot whose link was never written

	logic                  op_s1;
	logic [DATA_WIDTH-1:0] value_s1;
	logic [SLOT_W-1:0]     addr_s1;
	logic                  fresh_hit_s1;
	logic [SLOT_W-1:0]     link_rd_s1;
	logic [DATA_WIDTH-1:0] data_rd_s1;

	logic [SLOT_W-1:0]     rd_addr;
	logic [SLOT_W-1:0]     fresh_link;
	logic [SLOT_W-1:0]     link;
	logic                  slot_ok;

	logic [POP_W-1:0]      pop_value_q;
	logic [STATUS_W-1:0]   status_q;
	logic [SLOT_OUT_W-1:0] slot_used_q;

	// Push works on the free head, pop on the stack top
	assign rd_addr = (in_op == OP_POP) ? top_q : free_q;

	// Never-written slots still hold their reset chain
	assign fresh_link = (addr_s1 == SLOT_W'(SLOTS)) ? '0 : addr_s1 + SLOT_W'(1);
	assign link       = fresh_hit_s1 ? fresh_link : link_rd_s1;
	assign slot_ok    = (addr_s1 != '0) && (addr_s1 <= SLOT_W'(SLOTS));

	// Capture the word and read both memories at the head slot
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_s1        <= in_op;
			value_s1     <= DATA_WIDTH'(in_value);
			addr_s1      <= rd_addr;
			fresh_hit_s1 <= (rd_addr >= fresh_q);
			link_rd_s1   <= link_mem[rd_addr];
			data_rd_s1   <= data_mem[rd_addr];
		end
	end

	// Write back the relinked slot and the pushed word
	always_ff @(posedge clk) begin
		if (cmd.exec && slot_ok) begin
			if (op_s1 == OP_PUSH) begin
				link_mem[addr_s1] <= top_q;
				data_mem[addr_s1] <= value_s1;
			end else begin
				link_mem[addr_s1] <= free_q;
			end
		end
	end

	// Advance the heads and the fill mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q   <= '0;
			free_q  <= SLOT_W'(1);
			fresh_q <= SLOT_W'(1);
		end else if (cmd.exec && slot_ok) begin
			if (op_s1 == OP_PUSH) begin
				free_q <= link;
				top_q  <= addr_s1;
				if (addr_s1 == fresh_q) fresh_q <= fresh_q + SLOT_W'(1);
			end else begin
				top_q  <= link;
				free_q <= addr_s1;
			end
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (!slot_ok) begin
				pop_value_q <= '0;
				status_q    <= (op_s1 == OP_PUSH) ? STAT_FULL : STAT_EMPTY;
				slot_used_q <= '0;
			end else begin
				pop_value_q <= (op_s1 == OP_POP) ? POP_W'(data_rd_s1) : '0;
				status_q    <= STAT_DONE;
				slot_used_q <= SLOT_OUT_W'(addr_s1);
			end
		end
	end

	assign pop_value = pop_value_q;
	assign status    = status_q;
	assign slot_used = slot_used_q;
endmodule

// ===== sv/pooled_linked_stack.sv =====
// Linked stack over a fixed slot pool with free list: top level.
// Input channel s_*: s_tuser holds the operation (0 push, 1 pop), s_tdata
// the 32-bit word to push. Output channel m_*: one result word per input
// word, with the popped value and slot number in m_tdata and the status
// (0 done, 1 pool full, 2 stack empty) in m_tuser.
// Each operation is accepted, then executed: the accept edge reads the link
// and data memories at the head slot; the execute edge, held off while the
// output register holds an unread result, writes the slot back, moves the
// heads and loads the output register, raising m_tvalid. The link memory's
// read-then-write admits a word only once the previous one has executed.
// The output register holds a finished result while the next word is
// accepted; if m_tready stays low, the second operation waits in its
// execute cycle and s_tready stays low until the result drains.
// Reset empties the stack and chains all slots 1..SLOTS on the free list at
// once; slots not yet used are tracked by a fill mark, so no clearing pass
// is needed and words are accepted right after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pooled_linked_stack
	import pls_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,   // [31:0] push_value
	input  logic [0:0]            s_tuser,   // [0] cmd
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] pop_value, [42:32] slot_used, rest 0
	output logic [STATUS_W-1:0]   m_tuser    // [1:0] status
);
	pls_cmd_t              cmd;
	logic                  busy;
	logic [POP_W-1:0]      pop_value;
	logic [SLOT_OUT_W-1:0] slot_used;

	pls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.busy     (busy),
		.cmd      (cmd)
	);

	pls_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_op     (s_tuser[0]),
		.in_value  (s_tdata),
		.pop_value (pop_value),
		.status    (m_tuser),
		.slot_used (slot_used)
	);

	// Pack the result word
	assign m_tdata = {{(OUT_DATA_W - POP_W - SLOT_OUT_W){1'b0}}, slot_used, pop_value};

	`PLS_ASSERT_NOW(a_no_accept_in_exec, busy, !s_tready, "input accepted during execute")
	`PLS_ASSERT_NEXT(a_accept_starts_exec, s_tvalid && s_tready, busy,
		"accept did not start execute")
	`PLS_ASSERT_NOW(a_done_has_slot, m_tvalid && (m_tuser == STAT_DONE), slot_used != '0,
		"done result without slot")
	`PLS_ASSERT_NOW(a_fail_no_slot,
		m_tvalid && ((m_tuser == STAT_FULL) || (m_tuser == STAT_EMPTY)),
		(slot_used == '0) && (pop_value == '0), "failed result carries slot or value")
endmodule

// ===== dv/tb.sv =====
// Testbench for the pooled linked stack: random push/pop traffic checked against a local model.
`timescale 1ns / 1ps
module tb;
	import pls_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic        op;
		logic [31:0] word;
		bit          drain;   // hold this word until all results are back
	} stack_req_t;

	typedef struct {
		logic [POP_W-1:0]      value;
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] slot;
	} stack_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;   // [31:0] push_value
	logic [0:0]            s_tuser = '0;   // [0] cmd
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [31:0] pop_value, [42:32] slot_used, rest 0
	logic [STATUS_W-1:0]   m_tuser;        // [1:0] status

	// stimulus and expectations
	stack_req_t    pending_ops[$];
	stack_result_t awaited_results[$];
	int            gen_depth;

	// local copy of the stack state
	logic [SLOT_W-1:0]     top_idx;
	logic [SLOT_W-1:0]     free_idx;
	logic [SLOT_W-1:0]     next_link [0:SLOTS];
	logic [DATA_WIDTH-1:0] slot_word [0:SLOTS];

	int  n_push, n_pop, n_done, n_full, n_empty;
	int  fail_count;
	int  send_gap, recv_stall;
	bit  send_burst, recv_burst;
	int  cycle_cnt;

	pooled_linked_stack u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Queue one operation and track the stack depth it leaves behind.
	function automatic void queue_op(input logic op, input logic [31:0] word, input bit drain);
		stack_req_t r;
		r.op = op;
		r.word = word;
		r.drain = drain;
		pending_ops.push_back(r);
		if (op == OP_PUSH && gen_depth < SLOTS)
			gen_depth++;
		else if (op == OP_POP && gen_depth > 0)
			gen_depth--;
	endfunction

	// Mostly short gaps, a few long ones, none in a burst stretch.
	function automatic int draw_idle(input bit burst);
		int r;
		r = $urandom_range(99);
		if (burst || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Apply one accepted operation to the local stack and queue its result.
	function automatic void apply_stack_op(input logic op, input logic [31:0] word);
		stack_result_t     r;
		logic [SLOT_W-1:0] s;
		r.value = '0;
		r.status = STAT_DONE;
		r.slot = '0;
		if (op == OP_PUSH) begin
			n_push++;
			s = free_idx;
			if (s == 0 || s > SLOTS) begin
				r.status = STAT_FULL;
			end else begin
				free_idx = next_link[s];
				slot_word[s] = word[DATA_WIDTH-1:0];
				next_link[s] = top_idx;
				top_idx = s;
				r.slot = s;
			end
		end else begin
			n_pop++;
			s = top_idx;
			if (s == 0 || s > SLOTS) begin
				r.status = STAT_EMPTY;
			end else begin
				top_idx = next_link[s];
				r.value = POP_W'(slot_word[s]);
				next_link[s] = free_idx;
				free_idx = s;
				r.slot = s;
			end
		end
		case (r.status)
			STAT_DONE:  n_done++;
			STAT_FULL:  n_full++;
			default:    n_empty++;
		endcase
		awaited_results.push_back(r);
	endfunction

	function automatic void check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	// Drive input words from the pending queue, with random gaps.
	always @(posedge clk or negedge arst_n) begin : drive
		stack_req_t nxt;
		logic       nxt_valid;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_stack_op(s_tuser[0], s_tdata);
				if ((n_push + n_pop) % 97 == 0)
					send_burst = ($urandom_range(3) == 0);
				send_gap = draw_idle(send_burst);
			end
			if (!s_tvalid || s_tready) begin
				nxt_valid = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_ops.size() > 0 &&
					!(pending_ops[0].drain && awaited_results.size() > 0)) begin
					nxt = pending_ops.pop_front();
					nxt_valid = 1'b1;
					s_tdata <= nxt.word;
					s_tuser <= nxt.op;
				end
				s_tvalid <= nxt_valid;
			end
		end
	end

	// Check result words in order and stall the output at random.
	always @(posedge clk or negedge arst_n) begin : monitor
		stack_result_t want;
		logic          nxt_ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result expected none, got data %h status %h",
						$time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					check_field("pop_value", 64'(want.value), 64'(m_tdata[POP_W-1:0]));
					check_field("slot_used", 64'(want.slot),
						64'(m_tdata[POP_W +: SLOT_OUT_W]));
					check_field("tdata pad", 64'd0,
						64'(m_tdata[OUT_DATA_W-1:POP_W+SLOT_OUT_W]));
					check_field("status", 64'(want.status), 64'(m_tuser));
				end
			end
			nxt_ready = 1'b1;
			if (recv_stall > 0) begin
				recv_stall--;
				nxt_ready = 1'b0;
			end else if ($urandom_range(3) == 0) begin
				if ($urandom_range(63) == 0)
					recv_burst = ($urandom_range(3) == 0);
				recv_stall = draw_idle(recv_burst);
			end
			m_tready <= nxt_ready;
		end
	end

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		int i;
		// reset state: empty stack, every slot chained on the free list
		top_idx = '0;
		free_idx = SLOT_W'(1);
		next_link[0] = '0;
		for (i = 1; i < SLOTS; i++)
			next_link[i] = SLOT_W'(i + 1);
		next_link[SLOTS] = '0;
		for (i = 0; i <= SLOTS; i++)
			slot_word[i] = '0;
		gen_depth = 0;

		// directed: empty pops, extreme words, LIFO order, slot reuse
		queue_op(OP_POP, 32'h0, 0);
		queue_op(OP_PUSH, 32'h0000_0000, 0);
		queue_op(OP_PUSH, 32'hFFFF_FFFF, 0);
		queue_op(OP_PUSH, 32'hA5A5_A5A5, 0);
		queue_op(OP_POP, 32'h0, 0);
		queue_op(OP_POP, 32'hFFFF_FFFF, 0);
		queue_op(OP_POP, 32'h1234_5678, 0);
		queue_op(OP_POP, 32'hFFFF_FFFF, 0);
		queue_op(OP_PUSH, 32'h5555_5555, 0);
		queue_op(OP_PUSH, 32'hAAAA_AAAA, 0);
		queue_op(OP_POP, 32'h0, 0);
		queue_op(OP_PUSH, 32'h1234_5678, 0);
		queue_op(OP_PUSH, 32'h8000_0001, 0);
		queue_op(OP_POP, 32'h0, 0);
		queue_op(OP_POP, 32'h0, 0);
		queue_op(OP_POP, 32'h0, 0);
		queue_op(OP_POP, 32'h0, 0);
		queue_op(OP_PUSH, 32'h7FFF_FFFE, 0);
		queue_op(OP_POP, 32'hDEAD_BEEF, 0);

		// mixed traffic near the bottom, so empty pops recur
		for (i = 0; i < 30; i++)
			queue_op($urandom_range(1) ? OP_POP : OP_PUSH, $urandom, i == 0);
		// fill the whole pool, then hover around full
		while (gen_depth < SLOTS)
			queue_op(OP_PUSH, $urandom, 0);
		for (i = 0; i < 24; i++)
			queue_op(($urandom_range(99) < 60) ? OP_PUSH : OP_POP, $urandom, i == 0);
		// drain back down with mostly pops
		for (i = 0; i < 40; i++)
			queue_op(($urandom_range(99) < 85) ? OP_POP : OP_PUSH, $urandom, i == 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() > 0 || s_tvalid)
			@(posedge clk);
		while (awaited_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d pushes and %0d pops through the slot pool", n_push, n_pop);
		$display("results: %0d done, %0d pool full, %0d stack empty", n_done, n_full, n_empty);
		if (fail_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
